>>> hdl/csvyf_pkg.sv
// Shared types and constants for the CSV year row filter.
// Used by csvyf_line_parser, csvyf_line_judge and csv_year_row_filter.
package csvyf_pkg;

  typedef enum logic [2:0] {
    PH_SPACE = 3'b001,
    PH_SIGN  = 3'b010,
    PH_DIGIT = 3'b100
  } phase_t;

  typedef enum logic [2:0] {
    V_HEADER  = 3'd0,
    V_EMPTY   = 3'd1,
    V_KEPT    = 3'd2,
    V_DROPPED = 3'd3,
    V_ERROR   = 3'd4
  } verdict_t;

  localparam logic [1:0] REG_YEAR_COLUMN = 2'd0;
  localparam logic [1:0] REG_PREFIX_MODE = 2'd1;
  localparam logic [1:0] REG_YEAR_LOW    = 2'd2;
  localparam logic [1:0] REG_YEAR_HIGH   = 2'd3;

  localparam logic [5:0]  YEAR_COLUMN_RST = 6'd2;
  localparam logic [15:0] YEAR_LOW_RST    = 16'd2013;
  localparam logic [15:0] YEAR_HIGH_RST   = 16'd2024;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;

  typedef struct packed {
    logic        line_nonzero;
    logic        column_missing;
    logic        prefix_short;
    phase_t      phase;
    logic        negative;
    logic [31:0] magnitude;
    logic        overflow;
  } line_status_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [31:0] year_value;
    logic [31:0] total_rows;
    logic [31:0] saved_rows;
    logic [31:0] error_rows;
  } line_result_t;

endpackage

>>> hdl/csvyf_line_parser.sv
// Per-line CSV parser: quote handling, field counting and integer parsing.
// Depends on csvyf_pkg.
module csvyf_line_parser #(
  parameter int MAX_COLUMN   = 63,
  parameter int PREFIX_CHARS = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  logic [7:0]             byte_in,
  input  logic                   last_in,
  input  logic [5:0]             year_column,
  input  logic                   prefix_mode,
  output logic                   line_end,
  output csvyf_pkg::line_status_t status
);
  import csvyf_pkg::*;

  localparam int FW = $clog2(MAX_COLUMN + 2);
  localparam int CW = $clog2(PREFIX_CHARS + 1);

  logic          in_quotes, in_quotes_next;
  logic          quote_pending, quote_pending_next;
  logic          line_nonzero, line_nonzero_next;
  logic [FW-1:0] field_index, field_index_next;
  logic [CW-1:0] char_count, char_count_next;
  phase_t        phase, phase_next;
  logic          number_done, number_done_next;
  logic          negative, negative_next;
  logic [31:0]   magnitude, magnitude_next;
  logic          overflow, overflow_next;

  logic          add_en;
  logic          feed_en;
  logic          is_digit;
  logic          is_space;
  logic [34:0]   product;
  logic [FW-1:0] target;

  assign target = (32'(year_column) > 32'(MAX_COLUMN)) ? FW'(MAX_COLUMN) : FW'(year_column);
  assign is_digit = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
  assign is_space = (byte_in == CH_SPACE) || ((byte_in >= CH_TAB) && (byte_in <= CH_CR));
  assign product = ({3'b000, magnitude} << 3) + ({3'b000, magnitude} << 1)
                 + {31'd0, byte_in[3:0]};
  assign line_end = (byte_in == CH_NEWLINE) || last_in;

  always_comb begin
    in_quotes_next     = in_quotes;
    quote_pending_next = quote_pending;
    line_nonzero_next  = line_nonzero;
    field_index_next   = field_index;
    char_count_next    = char_count;
    phase_next         = phase;
    number_done_next   = number_done;
    negative_next      = negative;
    magnitude_next     = magnitude;
    overflow_next      = overflow;
    add_en             = 1'b0;
    feed_en            = 1'b0;

    if (byte_in != CH_NEWLINE) begin
      line_nonzero_next = 1'b1;
      if (quote_pending && (byte_in == CH_QUOTE)) begin
        quote_pending_next = 1'b0;
        add_en             = 1'b1;
      end else begin
        if (quote_pending) begin
          quote_pending_next = 1'b0;
          in_quotes_next     = 1'b0;
        end
        if (byte_in == CH_QUOTE) begin
          if (in_quotes_next) begin
            quote_pending_next = 1'b1;
          end else begin
            in_quotes_next = 1'b1;
          end
        end else if ((byte_in == CH_COMMA) && !in_quotes_next) begin
          if (field_index <= FW'(MAX_COLUMN)) begin
            field_index_next = field_index + FW'(1);
          end
        end else begin
          add_en = 1'b1;
        end
      end
    end

    if (add_en && (field_index == target)) begin
      if (prefix_mode) begin
        if (char_count < CW'(PREFIX_CHARS)) begin
          char_count_next = char_count + CW'(1);
          feed_en         = 1'b1;
        end
      end else begin
        feed_en = 1'b1;
      end
    end

    if (feed_en && !number_done) begin
      if (is_digit) begin
        if (!overflow) begin
          if (product > {3'b000, NEG_LIMIT}) begin
            overflow_next = 1'b1;
          end else begin
            magnitude_next = product[31:0];
          end
        end
        phase_next = PH_DIGIT;
      end else if ((phase == PH_SPACE) && is_space) begin
        phase_next = PH_SPACE;
      end else if ((phase == PH_SPACE) && ((byte_in == CH_PLUS) || (byte_in == CH_MINUS))) begin
        negative_next = (byte_in == CH_MINUS);
        phase_next    = PH_SIGN;
      end else begin
        number_done_next = 1'b1;
      end
    end
  end

  always_comb begin
    status.line_nonzero   = line_nonzero_next;
    status.column_missing = field_index_next < target;
    status.prefix_short   = prefix_mode && (char_count_next < CW'(PREFIX_CHARS));
    status.phase          = phase_next;
    status.negative       = negative_next;
    status.magnitude      = magnitude_next;
    status.overflow       = overflow_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (advance && line_end)) begin
      in_quotes     <= 1'b0;
      quote_pending <= 1'b0;
      line_nonzero  <= 1'b0;
      field_index   <= '0;
      char_count    <= '0;
      phase         <= PH_SPACE;
      number_done   <= 1'b0;
      negative      <= 1'b0;
      magnitude     <= '0;
      overflow      <= 1'b0;
    end else if (advance) begin
      in_quotes     <= in_quotes_next;
      quote_pending <= quote_pending_next;
      line_nonzero  <= line_nonzero_next;
      field_index   <= field_index_next;
      char_count    <= char_count_next;
      phase         <= phase_next;
      number_done   <= number_done_next;
      negative      <= negative_next;
      magnitude     <= magnitude_next;
      overflow      <= overflow_next;
    end
  end

endmodule

>>> hdl/csvyf_line_judge.sv
// Line-end verdict, year value and saturating row counters.
// Depends on csvyf_pkg.
module csvyf_line_judge (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    advance,
  input  logic                    line_end,
  input  logic                    file_end,
  input  csvyf_pkg::line_status_t status,
  input  logic [15:0]             year_low,
  input  logic [15:0]             year_high,
  output csvyf_pkg::line_result_t result
);
  import csvyf_pkg::*;

  logic        header_done, header_done_next;
  logic [31:0] total_rows, total_rows_next;
  logic [31:0] saved_rows, saved_rows_next;
  logic [31:0] error_rows, error_rows_next;
  verdict_t    verdict;
  logic [31:0] year;
  logic        in_range;

  assign in_range = !(status.negative && (status.magnitude != '0))
                  && (status.magnitude >= {16'd0, year_low})
                  && (status.magnitude <= {16'd0, year_high});

  always_comb begin
    header_done_next = header_done;
    total_rows_next  = total_rows;
    saved_rows_next  = saved_rows;
    error_rows_next  = error_rows;
    year             = '0;
    verdict          = V_EMPTY;

    if (!header_done) begin
      header_done_next = 1'b1;
      verdict          = V_HEADER;
    end else if (status.line_nonzero) begin
      if (total_rows != '1) begin
        total_rows_next = total_rows + 32'd1;
      end
      if (status.column_missing) begin
        verdict = V_ERROR;
      end else if (status.prefix_short) begin
        verdict = (year_low == '0) ? V_KEPT : V_DROPPED;
      end else if ((status.phase != PH_DIGIT) || status.overflow
                   || (!status.negative && (status.magnitude == NEG_LIMIT))) begin
        verdict = V_ERROR;
      end else begin
        year    = status.negative ? (32'd0 - status.magnitude) : status.magnitude;
        verdict = in_range ? V_KEPT : V_DROPPED;
      end
      if ((verdict == V_KEPT) && (saved_rows != '1)) begin
        saved_rows_next = saved_rows + 32'd1;
      end
      if ((verdict == V_ERROR) && (error_rows != '1)) begin
        error_rows_next = error_rows + 32'd1;
      end
    end
  end

  always_comb begin
    result.verdict    = verdict;
    result.year_value = year;
    result.total_rows = total_rows_next;
    result.saved_rows = saved_rows_next;
    result.error_rows = error_rows_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (advance && line_end && file_end)) begin
      header_done <= 1'b0;
      total_rows  <= '0;
      saved_rows  <= '0;
      error_rows  <= '0;
    end else if (advance && line_end) begin
      header_done <= header_done_next;
      total_rows  <= total_rows_next;
      saved_rows  <= saved_rows_next;
      error_rows  <= error_rows_next;
    end
  end

endmodule

>>> hdl/csv_year_row_filter.sv
// CSV year row filter: one file byte per transfer in, one result per line out.
// A byte is registered at its transfer; a line-end byte's result is registered for output when it advances.
// Throughput: one byte per cycle; a result held back by m_tready stalls the input register.
// Synchronous active-high reset returns configuration registers to defaults and clears all line state.
// Depends on csvyf_pkg, csvyf_line_parser and csvyf_line_judge.
module csv_year_row_filter #(
  parameter int MAX_COLUMN   = 63,
  parameter int PREFIX_CHARS = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // byte_req
  input  logic         s_tlast,   // last
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // year_value, total_rows, saved_rows, error_rows
  output logic [2:0]   m_tuser,   // verdict
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import csvyf_pkg::*;

  logic [5:0]   year_column;
  logic         prefix_mode;
  logic [15:0]  year_low;
  logic [15:0]  year_high;

  logic         in_valid;
  logic [7:0]   in_byte;
  logic         in_last;
  logic         advance;
  logic         line_end;
  line_status_t status;
  line_result_t result;
  line_result_t out_result;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      year_column <= YEAR_COLUMN_RST;
      prefix_mode <= 1'b0;
      year_low    <= YEAR_LOW_RST;
      year_high   <= YEAR_HIGH_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_YEAR_COLUMN: year_column <= pwdata[5:0];
        REG_PREFIX_MODE: prefix_mode <= pwdata[0];
        REG_YEAR_LOW:    year_low    <= pwdata[15:0];
        REG_YEAR_HIGH:   year_high   <= pwdata[15:0];
        default:         year_column <= year_column;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_YEAR_COLUMN: prdata = {26'd0, year_column};
      REG_PREFIX_MODE: prdata = {31'd0, prefix_mode};
      REG_YEAR_LOW:    prdata = {16'd0, year_low};
      REG_YEAR_HIGH:   prdata = {16'd0, year_high};
      default:         prdata = '0;
    endcase
  end

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  csvyf_line_parser #(
    .MAX_COLUMN   (MAX_COLUMN),
    .PREFIX_CHARS (PREFIX_CHARS)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .byte_in     (in_byte),
    .last_in     (in_last),
    .year_column (year_column),
    .prefix_mode (prefix_mode),
    .line_end    (line_end),
    .status      (status)
  );

  csvyf_line_judge u_judge (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .line_end  (line_end),
    .file_end  (in_last),
    .status    (status),
    .year_low  (year_low),
    .year_high (year_high),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && line_end) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && line_end) begin
      out_result <= result;
    end
  end

  assign m_tuser = out_result.verdict;
  assign m_tdata = {out_result.error_rows, out_result.saved_rows,
                    out_result.total_rows, out_result.year_value};

endmodule
